// ===== design/pru_pkg.sv =====
// Shared types, constants and codes for the pixel replicate upscaler.
// No dependencies; pru_front, pru_queue, pru_back and the top level import this package.
`default_nettype none

package pru_pkg;

   localparam int MAX_WIDTH_DEF = 1024;   // line store depth default
   localparam int MAX_SCALE     = 64;     // replication factor cap
   localparam int QUEUE_DEPTH   = 4;      // command queue between front and back
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int SCALE_W       = 7;
   localparam int COLS_W        = 11;
   localparam int ROWS_W        = 16;
   localparam int PIX_W         = 24;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   localparam logic FUNC_PIXEL  = 1'b0;
   localparam logic FUNC_REPLAY = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCALE  = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic {
      PHASE_LOAD   = 1'b0,
      PHASE_REPLAY = 1'b1
   } phase_type;

   typedef struct packed {
      logic       func;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [1:0] pad_bytes;
      logic       row_end;
      logic       frame_end;
      logic       phase_error;
      logic       run_last;
   } rsp_type;

   // Effective (clamped) configuration seen by the front end.
   typedef struct packed {
      logic [SCALE_W-1:0] scale;
      logic [COLS_W-1:0]  width;
      logic [ROWS_W-1:0]  height;
   } cfg_type;

   // One queued command: a run of identical output pixels.
   typedef struct packed {
      logic [PIX_W-1:0]   pixel;
      logic               from_store;
      logic [SCALE_W-1:0] count;
      logic [1:0]         pad_bytes;
      logic               row_end;
      logic               frame_end;
      logic               phase_error;
   } cmd_type;

endpackage : pru_pkg

`default_nettype wire

// ===== design/pru_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module pru_ram #(
   parameter int WIDTH  = 24,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WIDTH-1:0]  wdata,
   output      logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule : pru_ram

`default_nettype wire

// ===== design/pru_front.sv =====
// Front end: accepts items, checks the phase, tracks column/row/pass and
// drives the line store; hands one command per item to the queue. Uses pru_pkg.
`default_nettype none

module pru_front #(
   parameter int MAX_WIDTH = pru_pkg::MAX_WIDTH_DEF,
   parameter int ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire pru_pkg::cfg_type               cfg,
   input  wire logic                           restart,
   input  wire logic                           req_push,
   input  wire pru_pkg::req_type               req_data,
   output      logic                           req_full,
   input  wire logic [pru_pkg::QCOUNT_W-1:0]   queue_count,
   output      logic                           queue_push,
   output      pru_pkg::cmd_type               queue_cmd,
   output      logic                           ram_we,
   output      logic [ADDR_W-1:0]              ram_addr,
   output      logic [pru_pkg::PIX_W-1:0]      ram_wdata,
   input  wire logic [pru_pkg::PIX_W-1:0]      ram_rdata
);
   import pru_pkg::*;

   logic [ADDR_W-1:0]  col_ff, col_in;
   logic [ROWS_W-1:0]  row_ff, row_in;
   logic [SCALE_W-1:0] pass_ff, pass_in;
   phase_type          phase_ff, phase_in;
   logic               s1_valid_ff, s1_valid_in;
   cmd_type            s1_cmd_ff, s1_cmd_in;

   logic               accept;
   logic               want_replay;
   logic               mismatch;
   logic               row_last;
   logic [SCALE_W-1:0] pass_next;
   logic               row_done;
   logic               frame_last;
   logic [1:0]         pad;
   logic [PIX_W-1:0]   in_pixel;

   // Room for the item in flight plus this one.
   assign req_full = (32'(queue_count) + 32'(s1_valid_ff)) >= 32'(QUEUE_DEPTH);
   assign accept   = req_push && !req_full;

   assign want_replay = (req_data.func == FUNC_REPLAY);
   assign mismatch    = want_replay != (phase_ff == PHASE_REPLAY);
   assign in_pixel    = {req_data.red_in, req_data.green_in, req_data.blue_in};
   assign row_last    = (32'(col_ff) + 32'd1) >= 32'(cfg.width);
   assign pass_next   = (phase_ff == PHASE_REPLAY) ? pass_ff + SCALE_W'(1) : SCALE_W'(1);
   assign row_done    = pass_next >= cfg.scale;
   assign frame_last  = ({1'b0, row_ff} + 17'd1) >= {1'b0, cfg.height};
   // (width*scale) mod 4 only depends on the two low bits of each.
   assign pad         = 2'(cfg.width[1:0] * cfg.scale[1:0]);

   assign ram_we    = accept && !mismatch && !want_replay;
   assign ram_addr  = col_ff;
   assign ram_wdata = in_pixel;

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      pass_in     = pass_ff;
      phase_in    = phase_ff;
      s1_valid_in = accept;
      s1_cmd_in   = '0;

      if (mismatch) begin
         s1_cmd_in.count       = SCALE_W'(1);
         s1_cmd_in.phase_error = 1'b1;
      end else begin
         s1_cmd_in.pixel      = want_replay ? '0 : in_pixel;
         s1_cmd_in.from_store = want_replay;
         s1_cmd_in.count      = cfg.scale;
         s1_cmd_in.row_end    = row_last;
         s1_cmd_in.pad_bytes  = row_last ? pad : 2'd0;
         s1_cmd_in.frame_end  = row_last && row_done && frame_last;
      end

      if (restart) begin
         col_in   = '0;
         row_in   = '0;
         pass_in  = '0;
         phase_in = PHASE_LOAD;
      end else if (accept && !mismatch) begin
         if (row_last) begin
            col_in = '0;
            if (row_done) begin
               pass_in  = '0;
               phase_in = PHASE_LOAD;
               row_in   = frame_last ? '0 : row_ff + ROWS_W'(1);
            end else begin
               pass_in  = pass_next;
               phase_in = PHASE_REPLAY;
            end
         end else begin
            col_in = col_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         pass_ff     <= '0;
         phase_ff    <= PHASE_LOAD;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         pass_ff     <= pass_in;
         phase_ff    <= phase_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_cmd_ff <= s1_cmd_in;
   end

   // Merge the store read data, which lands in the cycle after accept.
   always_comb begin
      queue_cmd = s1_cmd_ff;
      if (s1_cmd_ff.from_store) begin
         queue_cmd.pixel = ram_rdata;
      end
   end

   assign queue_push = s1_valid_ff;

endmodule : pru_front

`default_nettype wire

// ===== design/pru_queue.sv =====
// Short command queue between front and back end.
// Uses pru_pkg.
`default_nettype none

module pru_queue (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire pru_pkg::cmd_type             push_cmd,
   input  wire logic                         pop,
   output      pru_pkg::cmd_type             head_cmd,
   output      logic                         head_valid,
   output      logic [pru_pkg::QCOUNT_W-1:0] count
);
   import pru_pkg::*;

   localparam int PW = (QPTR_W > 0) ? QPTR_W : 1;

   cmd_type              mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0]  count_ff, count_in;
   logic                 do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + QCOUNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - QCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign count      = count_ff;

endmodule : pru_queue

`default_nettype wire

// ===== design/pru_back.sv =====
// Back end: expands each queued command into its run of result pixels,
// one per cycle unless stalled, into the result register. Uses pru_pkg.
`default_nettype none

module pru_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire pru_pkg::cmd_type head_cmd,
   input  wire logic             head_valid,
   output      logic             head_pop,
   output      logic             rsp_empty,
   input  wire logic             rsp_pop,
   output      pru_pkg::rsp_type rsp_data
);
   import pru_pkg::*;

   logic [SCALE_W-1:0] beat_ff, beat_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;
   logic               load;
   logic               beat_last;

   assign beat_last = (beat_ff + SCALE_W'(1)) == head_cmd.count;
   assign load      = head_valid && (!out_valid_ff || rsp_pop);
   assign head_pop  = load && beat_last;

   always_comb begin
      beat_in      = beat_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (load) begin
         out_valid_in       = 1'b1;
         beat_in            = beat_last ? '0 : beat_ff + SCALE_W'(1);
         out_in.red_out     = head_cmd.pixel[23:16];
         out_in.green_out   = head_cmd.pixel[15:8];
         out_in.blue_out    = head_cmd.pixel[7:0];
         out_in.pad_bytes   = beat_last ? head_cmd.pad_bytes : 2'd0;
         out_in.row_end     = beat_last && head_cmd.row_end;
         out_in.frame_end   = beat_last && head_cmd.frame_end;
         out_in.phase_error = head_cmd.phase_error;
         out_in.run_last    = beat_last;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         beat_ff      <= beat_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule : pru_back

`default_nettype wire

// ===== design/pixel_replicate_upscaler.sv =====
// Top level of the nearest-neighbor integer upscaler: configuration
// registers plus front end, line store, command queue and back end.
// Depends on pru_pkg, pru_ram, pru_front, pru_queue and pru_back.
//
// Usage:
//   - Input channel (req_*): push a pixel item (func = pixel) or a replay item
//     (func = replay) while req_full is low. Send one row of width pixels,
//     then (scale-1)*width replay items, then the next row.
//   - Result channel (rsp_*): a result waits on rsp_data while rsp_empty is
//     low; rsp_pop takes it. Every item gives scale results (one result with
//     phase_error set if the item kind does not fit the phase).
//   - Configuration (csr_*): index 0 scale, 1 width, 2 height; csr_ready is
//     always high. A write to a listed register restarts the frame; write
//     only while the block is idle.
//   - Path: front end command register, queue, back end result register.
//     Throughput: one result per clock while the receiver keeps up, set by
//     the result register; an item's run ends before the next one starts.
//   - Reset: counters clear, phase goes to loading, configuration goes to 1.
//     The line store is not cleared; replays only read columns of the row.
//   - When the receiver stalls, the result register holds, the queue fills
//     and then req_full rises; no result is lost.
`default_nettype none

module pixel_replicate_upscaler #(
   parameter int MAX_WIDTH = pru_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   input  wire pru_pkg::req_type                req_data,
   output      logic                            req_full,
   output      logic                            rsp_empty,
   input  wire logic                            rsp_pop,
   output      pru_pkg::rsp_type                rsp_data,
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [pru_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pru_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pru_pkg::*;

   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // Raw register values as written.
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [COLS_W-1:0]  width_ff, width_in;
   logic [ROWS_W-1:0]  height_ff, height_in;
   logic               restart;
   cfg_type            cfg;

   logic [QCOUNT_W-1:0] queue_count;
   logic                queue_push;
   cmd_type             queue_cmd;
   cmd_type             head_cmd;
   logic                head_valid;
   logic                head_pop;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [PIX_W-1:0]  ram_wdata;
   logic [PIX_W-1:0]  ram_rdata;

   assign csr_ready = 1'b1;

   // Decode configuration writes; any listed register restarts the frame.
   always_comb begin
      scale_in  = scale_ff;
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_SCALE: begin
               scale_in = csr_wdata[SCALE_W-1:0];
               restart  = 1'b1;
            end
            CSR_WIDTH: begin
               width_in = csr_wdata[COLS_W-1:0];
               restart  = 1'b1;
            end
            CSR_HEIGHT: begin
               height_in = csr_wdata[ROWS_W-1:0];
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_W'(1);
         width_ff  <= COLS_W'(1);
         height_ff <= ROWS_W'(1);
      end else begin
         scale_ff  <= scale_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Clamp to the supported range: zero acts as one, overlarge as the cap.
   always_comb begin
      if (scale_ff == '0) begin
         cfg.scale = SCALE_W'(1);
      end else if (32'(scale_ff) > MAX_SCALE) begin
         cfg.scale = SCALE_W'(MAX_SCALE);
      end else begin
         cfg.scale = scale_ff;
      end
      if (width_ff == '0) begin
         cfg.width = COLS_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         cfg.width = COLS_W'(MAX_WIDTH);
      end else begin
         cfg.width = width_ff;
      end
      cfg.height = (height_ff == '0) ? ROWS_W'(1) : height_ff;
   end

   pru_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .ADDR_W    (ADDR_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .restart     (restart),
      .req_push    (req_push),
      .req_data    (req_data),
      .req_full    (req_full),
      .queue_count (queue_count),
      .queue_push  (queue_push),
      .queue_cmd   (queue_cmd),
      .ram_we      (ram_we),
      .ram_addr    (ram_addr),
      .ram_wdata   (ram_wdata),
      .ram_rdata   (ram_rdata)
   );

   // Line store: one input row of pixels.
   pru_ram #(
      .WIDTH  (PIX_W),
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_line_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   pru_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_cmd   (queue_cmd),
      .pop        (head_pop),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .count      (queue_count)
   );

   pru_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule : pixel_replicate_upscaler

`default_nettype wire
